// ===== hdl/mcc_pkg.sv =====
// Package for the masked census match cost block.
// Widths, register indexes, sequencer states, control and status structs.
// No dependencies.
`default_nettype none

package mcc_pkg;

  localparam int POS_W     = 6;    // row/column index
  localparam int CFG_W     = 7;    // configuration data
  localparam int REG_IDX_W = 2;    // configuration register index
  localparam int CODE_W    = 24;   // census code / mask
  localparam int POP_W     = 5;    // popcount of one code word
  localparam int CNT_W     = 17;   // totals and ratio
  localparam int MAX_PATCH = 64;   // patch side clamp
  localparam int DIV_STEPS = 16;   // fractional quotient bits
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [CNT_W-1:0] TOTAL_MAX = '1;
  localparam logic [CNT_W-1:0] Q16_ONE   = CNT_W'(65536);

  localparam logic [REG_IDX_W-1:0] REG_PATCH_SIZE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_X    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_VALID,
    ST_ADD_DIFF,
    ST_DIV_START,
    ST_DIV_WAIT
  } mcc_state_t;

  // accumulator control
  typedef struct packed {
    logic add;
    logic sel_diff;
    logic clear;
  } acc_ctl_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic empty;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/mcc_in_if.sv =====
// Input channel: one patch position with both census codes and masks.
// Depends on mcc_pkg.
`default_nettype none

interface mcc_in_if import mcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  row_index;
  logic [POS_W-1:0]  col_index;
  logic [CODE_W-1:0] left_code;
  logic [CODE_W-1:0] left_valid;
  logic [CODE_W-1:0] right_code;
  logic [CODE_W-1:0] right_valid;
  logic              final_pixel;

  modport source (output valid, row_index, col_index, left_code, left_valid,
                  right_code, right_valid, final_pixel, input ready);
  modport sink   (input valid, row_index, col_index, left_code, left_valid,
                  right_code, right_valid, final_pixel, output ready);
endinterface

`default_nettype wire

// ===== hdl/mcc_out_if.sv =====
// Output channel: totals and Q1.16 cost ratio for one patch.
// Depends on mcc_pkg.
`default_nettype none

interface mcc_out_if import mcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] differ_count;
  logic [CNT_W-1:0] valid_count;
  logic [CNT_W-1:0] cost_ratio;
  logic             no_valid_bits;

  modport source (output valid, differ_count, valid_count, cost_ratio,
                  no_valid_bits, input ready);
  modport sink   (input valid, differ_count, valid_count, cost_ratio,
                  no_valid_bits, output ready);
endinterface

`default_nettype wire

// ===== hdl/mcc_cfg_if.sv =====
// Configuration write channel: register index and data.
// Depends on mcc_pkg.
`default_nettype none

interface mcc_cfg_if import mcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/mcc_accum.sv =====
// Shared saturating accumulator: popcount of a selected mask word added
// to the valid or the differ total. Depends on mcc_pkg.
`default_nettype none

module mcc_accum import mcc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire acc_ctl_t          ctl,
  input  wire logic [CODE_W-1:0] both_mask,
  input  wire logic [CODE_W-1:0] diff_mask,
  output logic [CNT_W-1:0]       differ_total,
  output logic [CNT_W-1:0]       valid_total
);

  // popcount by nibbles, four one-bit adds per nibble
  function automatic logic [POP_W-1:0] pop24(input logic [CODE_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < CODE_W / 4; i++) begin
      n = n + POP_W'(v[4*i]) + POP_W'(v[4*i+1]) + POP_W'(v[4*i+2])
            + POP_W'(v[4*i+3]);
    end
    return n;
  endfunction

  logic [CODE_W-1:0] word;
  logic [CNT_W-1:0]  acc;
  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  sat;

  assign word = ctl.sel_diff ? diff_mask : both_mask;
  assign acc  = ctl.sel_diff ? differ_total : valid_total;
  assign sum  = {1'b0, acc} + (CNT_W + 1)'(pop24(word));
  assign sat  = sum[CNT_W] ? TOTAL_MAX : sum[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      differ_total <= '0;
      valid_total  <= '0;
    end else if (ctl.add) begin
      if (ctl.sel_diff) begin
        differ_total <= sat;
      end else begin
        valid_total <= sat;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mcc_div.sv =====
// Radix-2 restoring divider for the Q1.16 cost ratio, one bit a cycle,
// with round-half-up and cap at one. Depends on mcc_pkg.
`default_nettype none

module mcc_div import mcc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [CNT_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output div_stat_t             stat,
  output logic [CNT_W-1:0]      ratio
);

  logic              busy;
  logic              empty;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den;
  logic [CNT_W:0]    rem2;
  logic [CNT_W:0]    diff;
  logic [CNT_W-1:0]  half_up;

  assign rem2    = {rem, 1'b0};
  assign diff    = rem2 - {1'b0, den};
  assign half_up = den - (den >> 1);   // ceil(den / 2)

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= (divisor != '0) && (dividend < divisor);
    end else if (busy && steps == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      empty <= (divisor == '0);
      den   <= divisor;
      rem   <= dividend;
      steps <= STEP_W'(DIV_STEPS);
      if (divisor == '0) begin
        ratio <= '0;
      end else if (dividend >= divisor) begin
        ratio <= Q16_ONE;
      end else begin
        ratio <= '0;
      end
    end else if (busy) begin
      if (steps != '0) begin
        steps <= steps - 1'b1;
        if (!diff[CNT_W]) begin
          rem   <= diff[CNT_W-1:0];
          ratio <= {ratio[CNT_W-2:0], 1'b1};
        end else begin
          rem   <= rem2[CNT_W-1:0];
          ratio <= {ratio[CNT_W-2:0], 1'b0};
        end
      end else if (rem >= half_up) begin
        ratio <= ratio + 1'b1;
      end
    end
  end

  assign stat.busy  = busy;
  assign stat.empty = empty;

endmodule

`default_nettype wire

// ===== hdl/masked_census_match_cost.sv =====
// Top level of the masked census match cost block: sequencer, config
// registers, overlap test and output register. Uses mcc_pkg, the three
// channel interfaces, mcc_accum and mcc_div.
`default_nettype none

//  channel   | modport | word carried
//  ----------+---------+-------------------------------------------------
//  in_ch     | sink    | row/col, left and right census code and mask, last
//  out_ch    | source  | differ_count, valid_count, cost_ratio, no_valid_bits
//  cfg       | sink    | register index and 7-bit data
//
// Each word is accepted, then the AND-mask popcount is added, then the masked
// XOR popcount, all through one saturating adder. A final pixel adds a divider
// start state and a wait for the divider (16 quotient bits plus rounding; none
// for an empty mask or a ratio of one). Reset (rst, synchronous) clears the
// totals and loads patch_size 64, both shifts 0. The result sits in an output
// register; a new patch may start while it waits, but the next result holds in
// ST_DIV_WAIT until it has gone. cfg is always ready.

module masked_census_match_cost import mcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mcc_in_if.sink    in_ch,
  mcc_out_if.source out_ch,
  mcc_cfg_if.sink   cfg
);

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] patch_size;
  logic [CFG_W-1:0] shift_x;
  logic [CFG_W-1:0] shift_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      patch_size <= CFG_W'(64);
      shift_x    <= '0;
      shift_y    <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PATCH_SIZE: patch_size <= cfg.data;
        REG_SHIFT_X:    shift_x    <= cfg.data;
        REG_SHIFT_Y:    shift_y    <= cfg.data;
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // ------------------------------------------------------- overlap test
  // Patch side clamped to MAX_PATCH; a position counts when it and its
  // shifted partner both fall in [0, P).
  logic [CFG_W-1:0] p_eff;
  logic [POS_W+1:0] row_moved;   // signed
  logic [POS_W+1:0] col_moved;
  logic             row_in;
  logic             col_in;
  logic             hit;

  assign p_eff = (32'(patch_size) > MAX_PATCH) ? CFG_W'(MAX_PATCH) : patch_size;

  assign row_moved = {2'b00, in_ch.row_index} + {shift_y[CFG_W-1], shift_y};
  assign col_moved = {2'b00, in_ch.col_index} + {shift_x[CFG_W-1], shift_x};

  assign row_in = ({1'b0, in_ch.row_index} < p_eff) && !row_moved[POS_W+1]
                  && (row_moved[CFG_W-1:0] < p_eff);
  assign col_in = ({1'b0, in_ch.col_index} < p_eff) && !col_moved[POS_W+1]
                  && (col_moved[CFG_W-1:0] < p_eff);
  assign hit    = row_in && col_in;

  // ----------------------------------------------------- sequencer state
  mcc_state_t state;
  mcc_state_t state_next;

  logic [CODE_W-1:0] both_q;
  logic [CODE_W-1:0] diff_q;
  logic              hit_q;
  logic              last_q;

  logic              accept;
  logic              load_out;
  acc_ctl_t          acc_ctl;
  logic              div_start;
  div_stat_t         div_stat;

  logic [CNT_W-1:0]  differ_total;
  logic [CNT_W-1:0]  valid_total;
  logic [CNT_W-1:0]  ratio;

  logic              out_valid;
  logic              out_free;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input word latch: the masks the adder needs, the overlap hit and the last flag
  always_ff @(posedge clk) begin
    if (accept) begin
      both_q <= in_ch.left_valid & in_ch.right_valid;
      diff_q <= (in_ch.left_code ^ in_ch.right_code)
                & in_ch.left_valid & in_ch.right_valid;
      hit_q  <= hit;
      last_q <= in_ch.final_pixel;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (accept) state_next = ST_ADD_VALID;
      ST_ADD_VALID: state_next = ST_ADD_DIFF;
      ST_ADD_DIFF:  state_next = last_q ? ST_DIV_START : ST_IDLE;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (!div_stat.busy && out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    acc_ctl   = '0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_ADD_VALID: begin
        acc_ctl.add = hit_q;
      end
      ST_ADD_DIFF: begin
        acc_ctl.add      = hit_q;
        acc_ctl.sel_diff = 1'b1;
      end
      ST_DIV_START: begin
        div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
        load_out      = !div_stat.busy && out_free;
        acc_ctl.clear = load_out;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------ datapath units
  mcc_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .ctl          (acc_ctl),
    .both_mask    (both_q),
    .diff_mask    (diff_q),
    .differ_total (differ_total),
    .valid_total  (valid_total)
  );

  mcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (differ_total),
    .divisor  (valid_total),
    .stat     (div_stat),
    .ratio    (ratio)
  );

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.differ_count  <= differ_total;
      out_ch.valid_count   <= valid_total;
      out_ch.cost_ratio    <= ratio;
      out_ch.no_valid_bits <= div_stat.empty;
    end
  end

  assign out_ch.valid = out_valid;

  // ------------------------------------------------------------ assertions
  // masked differences are a subset of the common mask, saturation included
  a_differ_le_valid: assert property (@(posedge clk) disable iff (rst)
    differ_total <= valid_total)
    else $error("differ total exceeds valid total");

  // totals start from zero after a result is taken into the output register
  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (differ_total == '0 && valid_total == '0 && out_valid))
    else $error("totals not cleared after result load");

  // ratio never above one
  a_ratio_capped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_ch.cost_ratio <= Q16_ONE)
    else $error("cost ratio above one");

  // empty mask gives zero counts and zero ratio
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.no_valid_bits) |->
      (out_ch.cost_ratio == '0 && out_ch.valid_count == '0
       && out_ch.differ_count == '0))
    else $error("empty mask with non-zero result");

endmodule

`default_nettype wire
